### rtl/epe_pkg.sv
`timescale 1ns / 1ps
// Package for the Ethernet/IPv4 port extractor: result types, codes and byte offsets.
// Used by the channel interfaces and by every module of the block; depends on nothing.

package epe_pkg;

	// Class of a finished frame.
	typedef enum logic [2:0] {
		CLASS_OTHER = 3'd0,
		CLASS_IPV6  = 3'd1,
		CLASS_TCP   = 3'd2,
		CLASS_UDP   = 3'd3,
		CLASS_ICMP  = 3'd4
	} pkt_class_t;

	// Status of a finished frame.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_SHORT     = 2'd1,
		STATUS_TRUNCATED = 2'd2,
		STATUS_BAD_IHL   = 2'd3
	} status_t;

	// Byte offsets inside the frame.
	localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
	localparam logic [7:0] POS_TYPE_HI   = 8'd12;
	localparam logic [7:0] POS_TYPE_LO   = 8'd13;
	localparam logic [7:0] POS_IHL       = 8'd14;
	localparam logic [7:0] POS_PROTO     = 8'd23;
	localparam logic [7:0] PORT_BYTES    = 8'd4;

	// Header field values.
	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [3:0]  MIN_IHL      = 4'd5;

	// Fields captured while a frame streams through.
	typedef struct packed {
		logic [15:0] eth_type;
		logic [3:0]  header_words;
		logic [7:0]  ip_protocol;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} frame_fields_t;

	// One result request.
	typedef struct packed {
		pkt_class_t  pkt_class;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] frame_length;
		status_t     status;
	} result_t;

endpackage

### rtl/epe_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the port extractor: frame bytes in, results out.
// Depends on epe_pkg for the result types.

interface epe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface epe_result_if;
	logic                valid;
	logic                ready;
	epe_pkg::pkt_class_t pkt_class;
	logic [15:0]         src_port;
	logic [15:0]         dst_port;
	logic [15:0]         frame_length;
	epe_pkg::status_t    status;

	modport source (output valid, output pkt_class, output src_port, output dst_port,
		output frame_length, output status, input ready);
	modport sink (input valid, input pkt_class, input src_port, input dst_port,
		input frame_length, input status, output ready);
endinterface

### rtl/epe_capture.sv
`timescale 1ns / 1ps
// Per-frame capture state: saturating byte counter, ethertype, IHL, protocol and ports.
// Depends on epe_pkg. Presents the updated state for the byte being processed.

module epe_capture #(
	parameter int COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [7:0]                 byte_value,
	input  logic                       last_byte,
	output epe_pkg::frame_fields_t     fields_nxt,
	output logic [COUNT_BITS-1:0]      count_nxt
);

	epe_pkg::frame_fields_t  fields_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [7:0]              port_at;
	logic                    port_window;

	function automatic logic [COUNT_BITS-1:0] ext8(input logic [7:0] v);
		return {{(COUNT_BITS-8){1'b0}}, v};
	endfunction

	// First port byte sits right after the IPv4 header.
	assign port_at = epe_pkg::ETH_HDR_BYTES + {2'b00, fields_q.header_words, 2'b00};
	assign port_window = (count_q > ext8(epe_pkg::POS_IHL))
		&& (fields_q.eth_type == epe_pkg::ETYPE_IPV4)
		&& (fields_q.header_words >= epe_pkg::MIN_IHL);

	// Capture the header byte that matches the current position.
	always_comb begin
		fields_nxt = fields_q;
		if (count_q == ext8(epe_pkg::POS_TYPE_HI)) fields_nxt.eth_type[15:8] = byte_value;
		if (count_q == ext8(epe_pkg::POS_TYPE_LO)) fields_nxt.eth_type[7:0] = byte_value;
		if (count_q == ext8(epe_pkg::POS_IHL)) fields_nxt.header_words = byte_value[3:0];
		if (count_q == ext8(epe_pkg::POS_PROTO)) fields_nxt.ip_protocol = byte_value;
		if (port_window) begin
			if (count_q == ext8(port_at)) fields_nxt.src_port[15:8] = byte_value;
			if (count_q == ext8(port_at + 8'd1)) fields_nxt.src_port[7:0] = byte_value;
			if (count_q == ext8(port_at + 8'd2)) fields_nxt.dst_port[15:8] = byte_value;
			if (count_q == ext8(port_at + 8'd3)) fields_nxt.dst_port[7:0] = byte_value;
		end
	end

	// The counter holds at its maximum.
	assign count_nxt = (count_q != '1) ? count_q + 1'b1 : count_q;

	// State advances per byte and clears after the final byte of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_q <= '0;
			count_q  <= '0;
		end else if (en) begin
			if (last_byte) begin
				fields_q <= '0;
				count_q  <= '0;
			end else begin
				fields_q <= fields_nxt;
				count_q  <= count_nxt;
			end
		end
	end

endmodule

### rtl/epe_classify.sv
`timescale 1ns / 1ps
// Frame classification: turns the captured fields and byte count into one result.
// Depends on epe_pkg; purely combinational.

module epe_classify #(
	parameter int COUNT_BITS = 16
) (
	input  epe_pkg::frame_fields_t  fields,
	input  logic [COUNT_BITS-1:0]   count,
	output epe_pkg::result_t        result
);

	logic [7:0] port_end;

	function automatic logic [COUNT_BITS-1:0] ext8(input logic [7:0] v);
		return {{(COUNT_BITS-8){1'b0}}, v};
	endfunction

	// One past the last destination port byte.
	assign port_end = epe_pkg::ETH_HDR_BYTES + {2'b00, fields.header_words, 2'b00}
		+ epe_pkg::PORT_BYTES;

	// Checks in priority order: length, ethertype, IPv4 header, then protocol.
	always_comb begin
		result.pkt_class    = epe_pkg::CLASS_OTHER;
		result.src_port     = '0;
		result.dst_port     = '0;
		result.frame_length = 16'(count);
		result.status       = epe_pkg::STATUS_OK;
		if (count < ext8(epe_pkg::ETH_HDR_BYTES)) begin
			result.status = epe_pkg::STATUS_SHORT;
		end else if (fields.eth_type == epe_pkg::ETYPE_IPV6) begin
			result.pkt_class = epe_pkg::CLASS_IPV6;
		end else if (fields.eth_type != epe_pkg::ETYPE_IPV4) begin
			result.pkt_class = epe_pkg::CLASS_OTHER;
		end else if (count <= ext8(epe_pkg::POS_IHL)) begin
			result.status = epe_pkg::STATUS_TRUNCATED;
		end else if (fields.header_words < epe_pkg::MIN_IHL) begin
			result.status = epe_pkg::STATUS_BAD_IHL;
		end else if (count <= ext8(epe_pkg::POS_PROTO)) begin
			result.status = epe_pkg::STATUS_TRUNCATED;
		end else if (fields.ip_protocol == epe_pkg::PROTO_TCP
			|| fields.ip_protocol == epe_pkg::PROTO_UDP) begin
			result.pkt_class = (fields.ip_protocol == epe_pkg::PROTO_TCP)
				? epe_pkg::CLASS_TCP : epe_pkg::CLASS_UDP;
			if (count < ext8(port_end)) begin
				result.status = epe_pkg::STATUS_TRUNCATED;
			end else begin
				result.src_port = fields.src_port;
				result.dst_port = fields.dst_port;
			end
		end else if (fields.ip_protocol == epe_pkg::PROTO_ICMP) begin
			result.pkt_class = epe_pkg::CLASS_ICMP;
		end
	end

endmodule

### rtl/ethernet_ip_port_extractor_top.sv
`timescale 1ns / 1ps
// Top level of the Ethernet/IPv4 layer-4 port extractor.
// Depends on epe_pkg, epe_stream_if, epe_capture and epe_classify.

// The block takes one frame byte per cycle on the frame channel, with last_byte on the
// final byte, and returns one result request per frame on the result channel: the class
// (other, IPv6, TCP, UDP, ICMP), the TCP/UDP ports, the frame length and a status. A byte
// passes through an input register, the capture and classification logic, and the result
// register, so a result request is valid from the clock edge at which its final byte
// leaves the input register. It accepts a byte in every cycle except in one stall: a
// final byte that finds the result register full waits for the result channel to take
// that request. The byte counter is COUNT_BITS wide and saturates at 2^COUNT_BITS - 1.

module ethernet_ip_port_extractor_top #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	epe_byte_if.sink              frame,
	epe_result_if.source          result
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    last_s1;
	logic                    stall;
	logic                    advance;
	logic                    out_valid_q;
	epe_pkg::result_t        result_q;
	epe_pkg::frame_fields_t  fields_nxt;
	logic [COUNT_BITS-1:0]   count_nxt;
	epe_pkg::result_t        result_nxt;

	// A final byte may leave the input register only when the result register is free.
	assign stall   = valid_s1 && last_s1 && out_valid_q && !result.ready;
	assign advance = valid_s1 && !stall;
	assign frame.ready = !stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.byte_value;
			last_s1 <= frame.last_byte;
		end
	end

	epe_capture #(
		.COUNT_BITS(COUNT_BITS)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.fields_nxt (fields_nxt),
		.count_nxt  (count_nxt)
	);

	epe_classify #(
		.COUNT_BITS(COUNT_BITS)
	) u_classify (
		.fields (fields_nxt),
		.count  (count_nxt),
		.result (result_nxt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= result_nxt;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.pkt_class    = result_q.pkt_class;
	assign result.src_port     = result_q.src_port;
	assign result.dst_port     = result_q.dst_port;
	assign result.frame_length = result_q.frame_length;
	assign result.status       = result_q.status;

	// A final byte that leaves the input register always shows up as a result request.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid_q)
		else $error("final byte did not produce a result");

	// Ports are reported only for TCP and UDP frames.
	a_ports_only_l4: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.pkt_class != epe_pkg::CLASS_TCP
		&& result_q.pkt_class != epe_pkg::CLASS_UDP
		|-> result_q.src_port == 16'd0 && result_q.dst_port == 16'd0)
		else $error("ports reported for a frame without TCP or UDP");

	// A short frame is classed as other and is shorter than the Ethernet header.
	a_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status == epe_pkg::STATUS_SHORT
		|-> result_q.pkt_class == epe_pkg::CLASS_OTHER
		&& result_q.frame_length < 16'(epe_pkg::ETH_HDR_BYTES))
		else $error("short-frame status with wrong class or length");

	// A pending result request is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !(advance && last_s1))
		else $error("result register overwritten while still pending");

endmodule
